### rtl/core/bsfd_pkg.sv
// Shared types and constants for the byte-stuffed frame decoder.
package bsfd_pkg;

    typedef logic [7:0] t_byte;

    localparam t_byte SYNC_RESET = 8'hAA;

    typedef struct packed {
        logic  valid;
        t_byte data;
    } t_slot;

endpackage

### rtl/core/bsfd_ifs.sv
// Channel interfaces: received bytes, decoded results and the sync register write.
interface bsfd_rx_if import bsfd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface bsfd_res_if import bsfd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte frame_cmd;
    t_byte payload_byte;
    logic  has_data;
    logic  end_of_frame;
    t_byte decoded_length;

    modport source (
        output valid, output frame_cmd, output payload_byte, output has_data,
        output end_of_frame, output decoded_length, input ready
    );
    modport sink (
        input valid, input frame_cmd, input payload_byte, input has_data,
        input end_of_frame, input decoded_length, output ready
    );
endinterface

interface bsfd_cfg_if import bsfd_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/bsfd_in_stage.sv
// Input register for received bytes.
module bsfd_in_stage import bsfd_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bsfd_rx_if.sink        i_rx,
    input  logic           i_take,
    output t_slot          o_slot
);

    logic  r_valid;
    t_byte r_data;

    assign i_rx.ready = !r_valid || i_take;
    assign o_slot     = '{valid: r_valid, data: r_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_valid <= i_rx.valid;
        end
        if (i_rx.ready && i_rx.valid) begin
            r_data <= i_rx.rx_byte;
        end
    end

endmodule

### rtl/core/bsfd_decode.sv
// Frame parser state and result register.
module bsfd_decode import bsfd_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_slot          i_slot,
    output logic           o_take,
    bsfd_cfg_if.sink       i_cfg,
    bsfd_res_if.source     o_res
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_CMD,
        PH_LEN,
        PH_DATA
    } t_phase;

    t_phase r_phase, n_phase;
    t_byte  r_cmd, n_cmd;
    t_byte  r_rem, n_rem;
    logic   r_esc, n_esc;
    t_byte  r_cnt, n_cnt;
    t_byte  r_sync;

    logic   r_out_valid;
    t_byte  r_out_cmd, r_out_data, r_out_len;
    logic   r_out_has, r_out_eof;

    logic   emit;
    t_byte  e_data, e_len;
    logic   e_has, e_eof;
    t_byte  rem_dec;
    t_byte  cnt_inc;
    logic   is_sync;

    assign o_take  = i_slot.valid && (!r_out_valid || o_res.ready);
    assign rem_dec = r_rem - 8'd1;
    assign cnt_inc = r_cnt + 8'd1;
    assign is_sync = (i_slot.data == r_sync);

    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_rem   = r_rem;
        n_esc   = r_esc;
        n_cnt   = r_cnt;
        emit    = 1'b0;
        e_data  = '0;
        e_has   = 1'b0;
        e_eof   = 1'b0;
        e_len   = '0;
        case (r_phase)
            PH_HUNT: begin
                if (is_sync) begin
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                if (is_sync) begin
                    n_phase = PH_HUNT;
                end else begin
                    n_cmd   = i_slot.data;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_rem = i_slot.data;
                n_cnt = '0;
                n_esc = 1'b0;
                if (i_slot.data == 8'd0) begin
                    n_phase = PH_HUNT;
                    emit    = 1'b1;
                    e_eof   = 1'b1;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_rem = rem_dec;
                if (r_esc) begin
                    n_esc = 1'b0;
                    if (rem_dec == 8'd0) begin
                        n_phase = PH_HUNT;
                    end
                end else begin
                    n_cnt  = cnt_inc;
                    emit   = 1'b1;
                    e_data = i_slot.data;
                    e_has  = 1'b1;
                    if (is_sync && rem_dec != 8'd0) begin
                        n_esc = 1'b1;
                        e_eof = (rem_dec == 8'd1);
                    end else begin
                        e_eof = (rem_dec == 8'd0);
                        if (e_eof) begin
                            n_phase = PH_HUNT;
                        end
                    end
                    e_len = e_eof ? cnt_inc : 8'd0;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    assign i_cfg.ready         = 1'b1;
    assign o_res.valid          = r_out_valid;
    assign o_res.frame_cmd      = r_out_cmd;
    assign o_res.payload_byte   = r_out_data;
    assign o_res.has_data       = r_out_has;
    assign o_res.end_of_frame   = r_out_eof;
    assign o_res.decoded_length = r_out_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_cmd       <= '0;
            r_rem       <= '0;
            r_esc       <= 1'b0;
            r_cnt       <= '0;
            r_sync      <= SYNC_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_sync <= i_cfg.data;
            end
            if (o_take) begin
                r_phase <= n_phase;
                r_cmd   <= n_cmd;
                r_rem   <= n_rem;
                r_esc   <= n_esc;
                r_cnt   <= n_cnt;
            end
            if (o_take && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_take && emit) begin
            r_out_cmd  <= n_cmd;
            r_out_data <= e_data;
            r_out_has  <= e_has;
            r_out_eof  <= e_eof;
            r_out_len  <= e_len;
        end
    end

`ifndef SYNTH
    a_empty_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_has) |-> (r_out_eof && r_out_data == 8'd0 && r_out_len == 8'd0))
        else $error("empty result not a zero-length final");

    a_len_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_eof) |-> (r_out_len == 8'd0))
        else $error("length reported before end of frame");

    a_esc_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> (r_phase == PH_DATA))
        else $error("escape pending outside payload");

    a_data_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_rem != 8'd0))
        else $error("payload phase with no raw bytes left");

    a_stall_blocks_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !o_take)
        else $error("byte consumed while result stalled");
`endif

endmodule

### rtl/core/byte_stuffed_frame_decoder_unit.sv
// Top level of the byte-stuffed frame decoder.
// Decodes one received byte per clock unless the result is stalled: hunts for the
// sync byte, takes a command and a raw length, then unstuffs the payload (a sync
// byte inside the payload stands for one sync value and the raw byte after it is
// dropped). Each decoded payload byte gives one result; the last result of a
// frame carries the decoded length, and a zero-length frame gives one empty final
// result. A byte passes an input register and one decision step into the result
// register, and a byte can be taken every cycle while the result is not stalled;
// the rate is set by the single state update per byte. A stalled result holds
// the decode step, and the input register holds at most one more byte behind it.
// The sync value (reset 0xAA) is written through the configuration channel; the
// user must write it only while the decoder is idle: the block does not enforce it.
module byte_stuffed_frame_decoder_unit import bsfd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bsfd_rx_if.sink    i_rx,
    bsfd_cfg_if.sink   i_cfg,
    bsfd_res_if.source o_res
);

    t_slot slot;
    logic  take;

    bsfd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (take),
        .o_slot  (slot)
    );

    bsfd_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_slot  (slot),
        .o_take  (take),
        .i_cfg   (i_cfg),
        .o_res   (o_res)
    );

endmodule
